@@ design/tagged_value_stream_parser_core_assert.svh @@
// ---------------------------------------------------------------------------
// tagged value stream parser assertion macros
// clocked property checks; these compile to nothing under synthesis
// ---------------------------------------------------------------------------
`ifndef TAGGED_VALUE_STREAM_PARSER_CORE_ASSERT_SVH
`define TAGGED_VALUE_STREAM_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property checked outside reset
`define TVSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define TVSP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TVSP_ASSERT(label, clk, rst, prop, msg)
`define TVSP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ design/tvsp_pkg.sv @@
// ---------------------------------------------------------------------------
// tvsp_pkg
// shared types, codes and decode helpers of the tagged value stream parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvsp_pkg;

   // widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ROLE_W   = 3;
   localparam int unsigned COUNT_W  = 24;
   localparam int unsigned SEEN_W   = 2;
   localparam int unsigned SIZE_W   = 4;

   // number of little-endian length bytes of a string (1 to 3)
   localparam int unsigned LENGTH_BYTES_DEFAULT = 3;

   // byte roles
   localparam logic [ROLE_W-1:0] ROLE_TYPE = 3'd0;
   localparam logic [ROLE_W-1:0] ROLE_LEN  = 3'd1;
   localparam logic [ROLE_W-1:0] ROLE_PAY  = 3'd2;
   localparam logic [ROLE_W-1:0] ROLE_END  = 3'd3;
   localparam logic [ROLE_W-1:0] ROLE_ERR  = 3'd4;

   // type codes
   localparam logic [BYTE_W-1:0] TYPE_END    = 8'd0;
   localparam logic [BYTE_W-1:0] TYPE_UINT16 = 8'd1;
   localparam logic [BYTE_W-1:0] TYPE_UINT32 = 8'd2;
   localparam logic [BYTE_W-1:0] TYPE_UINT64 = 8'd3;
   localparam logic [BYTE_W-1:0] TYPE_INT16  = 8'd4;
   localparam logic [BYTE_W-1:0] TYPE_INT32  = 8'd5;
   localparam logic [BYTE_W-1:0] TYPE_INT64  = 8'd6;
   localparam logic [BYTE_W-1:0] TYPE_BYTE   = 8'd7;
   localparam logic [BYTE_W-1:0] TYPE_STRING = 8'd10;

   // parser phase, one-hot
   typedef enum logic [2:0] {
      PH_TYPE = 3'b001,
      PH_LEN  = 3'b010,
      PH_PAY  = 3'b100
   } phase_type;

   // one result item
   typedef struct packed {
      logic [ROLE_W-1:0]  byte_role;
      logic [BYTE_W-1:0]  value_type;
      logic [BYTE_W-1:0]  data_out;
      logic [COUNT_W-1:0] payload_offset;
      logic               value_done;
      logic [COUNT_W-1:0] string_length;
   } result_type;

   // payload size of a fixed-size type, zero for any other code
   function automatic logic [SIZE_W-1:0] fixed_size(input logic [BYTE_W-1:0] code);
      logic [SIZE_W-1:0] size;
      case (code)
         TYPE_UINT16, TYPE_INT16: size = 4'd2;
         TYPE_UINT32, TYPE_INT32: size = 4'd4;
         TYPE_UINT64, TYPE_INT64: size = 4'd8;
         TYPE_BYTE:               size = 4'd1;
         default:                 size = 4'd0;
      endcase
      return size;
   endfunction

endpackage

@@ design/tvsp_in_reg.sv @@
// ---------------------------------------------------------------------------
// tvsp_in_reg
// input register: holds one accepted byte until the parse stage takes it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvsp_in_reg
   import tvsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              take,
   output logic              held_valid,
   output logic [BYTE_W-1:0] held_byte
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              load;

   // room when empty or when the held item moves on this cycle
   assign in_ready = !valid_ff || take;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= in_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

@@ design/tvsp_parse.sv @@
// ---------------------------------------------------------------------------
// tvsp_parse
// parser state and the per-byte classification logic
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tagged_value_stream_parser_core_assert.svh"

module tvsp_parse
   import tvsp_pkg::*;
#(
   parameter int unsigned LENGTH_BYTES = LENGTH_BYTES_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] data_byte,
   output result_type        result
);

   localparam logic [SEEN_W-1:0] LEN_NEEDED = SEEN_W'(LENGTH_BYTES);

   phase_type          phase_ff,     phase_in;
   logic [BYTE_W-1:0]  cur_type_ff,  cur_type_in;
   logic [COUNT_W-1:0] remaining_ff, remaining_in;
   logic [SEEN_W-1:0]  seen_ff,      seen_in;
   logic [COUNT_W-1:0] acc_ff,       acc_in;
   logic [COUNT_W-1:0] offset_ff,    offset_in;

   logic [SIZE_W-1:0]  size;
   logic [COUNT_W-1:0] acc_merge;
   logic [SEEN_W-1:0]  seen_next;
   logic               last_pay;

   assign size      = fixed_size(data_byte);
   assign seen_next = seen_ff + 1'b1;
   assign last_pay  = (remaining_ff[COUNT_W-1:1] == '0);

   // place the length byte by its position
   always_comb begin
      case (seen_ff)
         2'd0:    acc_merge = acc_ff | {16'd0, data_byte};
         2'd1:    acc_merge = acc_ff | {8'd0, data_byte, 8'd0};
         2'd2:    acc_merge = acc_ff | {data_byte, 16'd0};
         default: acc_merge = acc_ff;
      endcase
   end

   // next state and result for the byte at hand
   always_comb begin
      phase_in     = phase_ff;
      cur_type_in  = cur_type_ff;
      remaining_in = remaining_ff;
      seen_in      = seen_ff;
      acc_in       = acc_ff;
      offset_in    = offset_ff;

      result.byte_role      = ROLE_TYPE;
      result.value_type     = data_byte;
      result.data_out       = data_byte;
      result.payload_offset = '0;
      result.value_done     = 1'b0;
      result.string_length  = '0;

      case (phase_ff)
         PH_LEN: begin
            result.byte_role     = ROLE_LEN;
            result.value_type    = cur_type_ff;
            result.string_length = acc_merge;
            acc_in               = acc_merge;
            seen_in              = seen_next;
            if (seen_next >= LEN_NEEDED) begin
               if (acc_merge == '0) begin
                  result.value_done = 1'b1;
                  phase_in          = PH_TYPE;
               end else begin
                  phase_in     = PH_PAY;
                  remaining_in = acc_merge;
                  offset_in    = '0;
               end
            end
         end
         PH_PAY: begin
            result.byte_role      = ROLE_PAY;
            result.value_type     = cur_type_ff;
            result.payload_offset = offset_ff;
            result.string_length  = (cur_type_ff == TYPE_STRING) ? acc_ff : '0;
            offset_in             = offset_ff + 1'b1;
            if (last_pay) begin
               remaining_in      = '0;
               result.value_done = 1'b1;
               phase_in          = PH_TYPE;
            end else begin
               remaining_in = remaining_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_TYPE;
            if (data_byte == TYPE_END) begin
               result.byte_role = ROLE_END;
            end else if (size != '0) begin
               cur_type_in  = data_byte;
               remaining_in = COUNT_W'(size);
               offset_in    = '0;
               phase_in     = PH_PAY;
            end else if (data_byte == TYPE_STRING) begin
               cur_type_in  = data_byte;
               seen_in      = '0;
               acc_in       = '0;
               remaining_in = '0;
               offset_in    = '0;
               phase_in     = PH_LEN;
            end else begin
               result.byte_role = ROLE_ERR;
            end
         end
      endcase
   end

   // state update once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         cur_type_ff  <= '0;
         remaining_ff <= '0;
         seen_ff      <= '0;
         acc_ff       <= '0;
         offset_ff    <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         cur_type_ff  <= cur_type_in;
         remaining_ff <= remaining_in;
         seen_ff      <= seen_in;
         acc_ff       <= acc_in;
         offset_ff    <= offset_in;
      end
   end

   // payload phase always has at least one byte due
   `TVSP_ASSERT(a_pay_remaining, clock, reset, (phase_ff == PH_PAY) |-> (remaining_ff != '0), "payload phase with no bytes remaining")

   // a completed value returns the parser to the type phase
   `TVSP_ASSERT(a_done_to_type, clock, reset, (step && result.value_done) |=> (phase_ff == PH_TYPE), "value done but parser not back in type phase")

   // reset always lands in the type phase
   `TVSP_ASSERT_ALWAYS(a_reset_phase, clock, reset |=> (phase_ff == PH_TYPE), "phase not cleared by reset")

endmodule

@@ design/tvsp_out_reg.sv @@
// ---------------------------------------------------------------------------
// tvsp_out_reg
// result register: holds one result item until the consumer takes it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvsp_out_reg
   import tvsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result_in,
   input  logic       out_ready,
   output logic       out_valid,
   output logic       can_load,
   output result_type result_out
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // free when empty or when the held item leaves this cycle
   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign result_out = result_ff;

endmodule

@@ design/tagged_value_stream_parser_core.sv @@
// Path: an accepted item waits in the input register, is parsed, and is held in the result register
// until taken; a full result register holds it back (one input register, one result register).
// Throughput: one item per cycle while rsp_tready stays high; the parse state updates once per byte.
// Reset: synchronous, active high; both registers empty, parser expects a type byte.
// ---------------------------------------------------------------------------
// tagged_value_stream_parser_core
// classifies each byte of a tagged value stream: type, length, payload,
// message end or unknown-type error
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tagged_value_stream_parser_core
   import tvsp_pkg::*;
#(
   parameter int unsigned LENGTH_BYTES = LENGTH_BYTES_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   // request item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] data_out, [31:8] payload_offset,
                                    // [55:32] string_length
   output logic [10:0] rsp_tuser,   // [2:0] byte_role, [10:3] value_type
   output logic        rsp_tlast    // value_done
);

   logic              held_valid;
   logic [BYTE_W-1:0] held_byte;
   logic              can_load;
   logic              advance;
   result_type        parsed;
   result_type        out_item;

   // move the held byte on when the result register has room
   assign advance = held_valid && can_load;

   tvsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .take       (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   tvsp_parse #(
      .LENGTH_BYTES (LENGTH_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (held_byte),
      .result    (parsed)
   );

   tvsp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result_in  (parsed),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .can_load   (can_load),
      .result_out (out_item)
   );

   // pack the result item
   assign rsp_tdata = {out_item.string_length, out_item.payload_offset, out_item.data_out};
   assign rsp_tuser = {out_item.value_type, out_item.byte_role};
   assign rsp_tlast = out_item.value_done;

endmodule
